FILE: rtl/psz_pkg.sv
// shared types, constants and helpers for the point splat z-buffer shader
// no dependencies
`timescale 1ns / 1ps

package psz_pkg;

   // default screen size
   localparam int unsigned SCREEN_W_DEF = 40;
   localparam int unsigned SCREEN_H_DEF = 40;

   // command codes on req_tuser
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_PLOT  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_SCREEN_DIST = 2'd0;
   localparam logic [1:0] CSR_LIGHT_X     = 2'd1;
   localparam logic [1:0] CSR_LIGHT_Y     = 2'd2;
   localparam logic [1:0] CSR_LIGHT_Z     = 2'd3;

   localparam logic [14:0] SCREEN_DIST_RST = 15'd3840;
   localparam logic [13:0] LIGHT_X_RST     = 14'sd0;
   localparam logic [13:0] LIGHT_Y_RST     = -14'sd4096;
   localparam logic [13:0] LIGHT_Z_RST     = 14'sd0;

   localparam logic [6:0] CHAR_SPACE = 7'd32;
   localparam logic [3:0] SHADE_MID  = 4'd6;

   // serial multiplier command
   typedef struct packed {
      logic       start;
      logic       clr;
      logic       neg;
      logic [5:0] nbits;
   } mul_cmd_type;

   // serial divider command
   typedef struct packed {
      logic       start;
      logic [5:0] qbits;
   } div_cmd_type;

   // one pixel store word
   typedef struct packed {
      logic        valid;
      logic [15:0] depth;
      logic [3:0]  shade;
   } pix_word_type;

   function automatic logic [15:0] abs16(input logic [15:0] v);
      abs16 = v[15] ? 16'(-v) : v;
   endfunction

   function automatic logic [13:0] abs14(input logic [13:0] v);
      abs14 = v[13] ? 14'(-v) : v;
   endfunction

   // shade level to character ".,-~:;=!*#$@", levels above 11 clamp
   function automatic logic [6:0] shade_char(input logic [3:0] sh);
      case (sh)
         4'd0:    shade_char = 7'd46;
         4'd1:    shade_char = 7'd44;
         4'd2:    shade_char = 7'd45;
         4'd3:    shade_char = 7'd126;
         4'd4:    shade_char = 7'd58;
         4'd5:    shade_char = 7'd59;
         4'd6:    shade_char = 7'd61;
         4'd7:    shade_char = 7'd33;
         4'd8:    shade_char = 7'd42;
         4'd9:    shade_char = 7'd35;
         4'd10:   shade_char = 7'd36;
         default: shade_char = 7'd64;
      endcase
   endfunction

endpackage

FILE: rtl/psz_mul.sv
// bit-serial shift-add multiply-accumulate, one multiplier bit per cycle
// depends on psz_pkg
`timescale 1ns / 1ps

module psz_mul (
   input  logic                clock,
   input  logic                reset,
   input  psz_pkg::mul_cmd_type cmd,
   input  logic [31:0]         a_mag,
   input  logic [31:0]         b_mag,
   output logic signed [63:0]  acc,
   output logic                done
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic [63:0]        a_ff, a_in;
   logic [31:0]        b_ff, b_in;
   logic signed [63:0] acc_ff, acc_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.nbits;
         neg_in  = cmd.neg;
         a_in    = 64'(a_mag);
         b_in    = b_mag;
         if (cmd.clr) begin
            acc_in = '0;
         end
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = neg_ff ? acc_ff - $signed(a_ff) : acc_ff + $signed(a_ff);
         end
         a_in   = {a_ff[62:0], 1'b0};
         b_in   = {1'b0, b_ff[31:1]};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

FILE: rtl/psz_div.sv
// restoring divider, one quotient bit per cycle
// depends on psz_pkg
`timescale 1ns / 1ps

module psz_div (
   input  logic                 clock,
   input  logic                 reset,
   input  psz_pkg::div_cmd_type cmd,
   input  logic [55:0]          rem_init,
   input  logic [63:0]          num_sh,
   input  logic [54:0]          den,
   output logic [30:0]          quo,
   output logic [55:0]          rem,
   output logic                 done
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [55:0] rem_ff, rem_in;
   logic [63:0] num_ff, num_in;
   logic [54:0] den_ff, den_in;
   logic [30:0] quo_ff, quo_in;
   logic [55:0] trial;
   logic        ge;

   assign trial = {rem_ff[54:0], num_ff[63]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.qbits;
         rem_in  = rem_init;
         num_in  = num_sh;
         den_in  = den;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? trial - {1'b0, den_ff} : trial;
         num_in = {num_ff[62:0], 1'b0};
         quo_in = {quo_ff[29:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quo  = quo_ff;
   assign rem  = rem_ff;
   assign done = done_ff;

endmodule

FILE: rtl/psz_pixmem.sv
// pixel store: valid, depth and shade per pixel, with a clearing sweep
// depends on psz_pkg
`timescale 1ns / 1ps

module psz_pixmem #(
   parameter int unsigned NPIX = psz_pkg::SCREEN_W_DEF * psz_pkg::SCREEN_H_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clr_start,
   output logic                      clr_busy,
   input  logic                      rd_en,
   input  logic [$clog2(NPIX)-1:0]   rd_addr,
   output psz_pkg::pix_word_type     rd_data,
   input  logic                      wr_en,
   input  logic [$clog2(NPIX)-1:0]   wr_addr,
   input  psz_pkg::pix_word_type     wr_data
);

   localparam int unsigned AW = $clog2(NPIX);

   psz_pkg::pix_word_type mem [NPIX];
   psz_pkg::pix_word_type rd_ff;
   logic                  busy_ff, busy_in;
   logic [AW-1:0]         addr_ff, addr_in;

   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      if (clr_start) begin
         busy_in = 1'b1;
         addr_in = '0;
      end else if (busy_ff) begin
         addr_in = addr_ff + AW'(1);
         if (addr_ff == AW'(NPIX - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         addr_ff <= addr_in;
      end
   end

   // sweep has the write port while it runs
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_ff;
   assign clr_busy = busy_ff;

endmodule

FILE: rtl/point_splat_zbuffer_shader.sv
// point splat z-buffer shader top level: command sequencer, registers, result stage
// depends on psz_pkg, psz_mul, psz_div, psz_pixmem
`timescale 1ns / 1ps
//
// channel  | dir | fields
// ---------+-----+------------------------------------------------------------
// req_     | in  | tuser: cmd; tdata: pos_x, pos_y, pos_z, norm_x, norm_y,
//          |     |   norm_z, pixel_index
// rsp_     | out | tdata: plotted, pixel_hit, char_code
// csr_     | in  | write only: csr_we, csr_addr, csr_wdata
//
// one command at a time. a plot runs the shared bit-serial multiplier
// (one multiplier bit per cycle) for two projection products and
// seven shading products, and the shared restoring divider (one quotient bit per
// cycle) for two 31 bit projection divides and one 9 bit shading divide.
// a clear starts a sweep over all SCREEN_W*SCREEN_H entries of the pixel store,
// during which no command is taken.
// after reset the same sweep runs before the first transfer is taken.
// a finished result waits in the rsp_ register; the next command is accepted
// meanwhile and stalls only at its own end if that register is still full.

module point_splat_zbuffer_shader #(
   parameter int unsigned SCREEN_W = psz_pkg::SCREEN_W_DEF,
   parameter int unsigned SCREEN_H = psz_pkg::SCREEN_H_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x[15:0] pos_y[31:16] pos_z[47:32] norm_x[63:48] norm_y[79:64]
   // norm_z[95:80] pixel_index[106:96], zero pad above
   input  logic [111:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // plotted[0] pixel_hit[1] char_code[8:2], zero pad above
   output logic [15:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [14:0]  csr_wdata
);

   localparam int unsigned NPIX  = SCREEN_W * SCREEN_H;
   localparam int unsigned AW    = $clog2(NPIX);
   localparam int unsigned XW    = $clog2(SCREEN_W);
   localparam int unsigned YW    = $clog2(SCREEN_H);
   localparam int unsigned XHALF = SCREEN_W / 2;
   localparam int unsigned YHALF = SCREEN_H / 2;
   localparam int unsigned XREST = SCREEN_W - XHALF;
   localparam int unsigned YREST = SCREEN_H - YHALF;

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_PCHK  = 4'd1;
   localparam logic [3:0] ST_XMUL  = 4'd2;
   localparam logic [3:0] ST_XDIV  = 4'd3;
   localparam logic [3:0] ST_YMUL  = 4'd4;
   localparam logic [3:0] ST_YDIV  = 4'd5;
   localparam logic [3:0] ST_SHMUL = 4'd6;
   localparam logic [3:0] ST_SHDIV = 4'd7;
   localparam logic [3:0] ST_RD    = 4'd8;
   localparam logic [3:0] ST_RDW   = 4'd9;
   localparam logic [3:0] ST_DONE  = 4'd10;

   // multiplier jobs
   localparam logic [3:0] OP_PX   = 4'd0;
   localparam logic [3:0] OP_PY   = 4'd1;
   localparam logic [3:0] OP_NXX  = 4'd2;
   localparam logic [3:0] OP_NYY  = 4'd3;
   localparam logic [3:0] OP_NZZ  = 4'd4;
   localparam logic [3:0] OP_NXL  = 4'd5;
   localparam logic [3:0] OP_NYL  = 4'd6;
   localparam logic [3:0] OP_NZL  = 4'd7;
   localparam logic [3:0] OP_SSQ  = 4'd8;

   // configuration registers
   logic [14:0]        sd_ff;
   logic signed [13:0] lx_ff, ly_ff, lz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_ff <= psz_pkg::SCREEN_DIST_RST;
         lx_ff <= psz_pkg::LIGHT_X_RST;
         ly_ff <= psz_pkg::LIGHT_Y_RST;
         lz_ff <= psz_pkg::LIGHT_Z_RST;
      end else if (csr_we) begin
         case (csr_addr)
            psz_pkg::CSR_SCREEN_DIST: sd_ff <= csr_wdata;
            psz_pkg::CSR_LIGHT_X:     lx_ff <= csr_wdata[13:0];
            psz_pkg::CSR_LIGHT_Y:     ly_ff <= csr_wdata[13:0];
            psz_pkg::CSR_LIGHT_Z:     lz_ff <= csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   // control and captured command
   logic [3:0]  state_ff, state_in;
   logic [3:0]  term_ff, term_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [15:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [15:0] nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;
   logic [10:0] pidx_ff, pidx_in;
   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic        nneg_ff, nneg_in;
   logic [31:0] m_ff, m_in;
   logic [30:0] s_ff, s_in;
   logic [3:0]  shade_ff, shade_in;
   logic        res_plot_ff, res_plot_in;
   logic        res_hit_ff, res_hit_in;
   logic [6:0]  res_char_ff, res_char_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0] rsp_tdata_ff, rsp_tdata_in;

   // shared units
   psz_pkg::mul_cmd_type mul_cmd;
   logic                 mul_start;
   logic [3:0]           op_sel;
   logic [31:0]          mul_a, mul_b;
   logic signed [63:0]   mul_acc;
   logic                 mul_done;
   psz_pkg::div_cmd_type div_cmd;
   logic [55:0]          div_rem_init;
   logic [63:0]          div_num;
   logic [54:0]          div_den;
   logic [30:0]          div_quo;
   logic [55:0]          div_rem;
   logic                 div_done;

   // pixel store
   logic                  clr_start, clr_busy;
   logic                  rd_en, wr_en;
   logic [AW-1:0]         pix_addr;
   psz_pkg::pix_word_type rd_data, wr_data;

   psz_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .a_mag (mul_a),
      .b_mag (mul_b),
      .acc   (mul_acc),
      .done  (mul_done)
   );

   psz_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .rem_init (div_rem_init),
      .num_sh   (div_num),
      .den      (div_den),
      .quo      (div_quo),
      .rem      (div_rem),
      .done     (div_done)
   );

   psz_pixmem #(.NPIX(NPIX)) u_pixmem (
      .clock     (clock),
      .reset     (reset),
      .clr_start (clr_start),
      .clr_busy  (clr_busy),
      .rd_en     (rd_en),
      .rd_addr   (pix_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (pix_addr),
      .wr_data   (wr_data)
   );

   // multiplier operands for each job
   // the square of s starts while s is still in the accumulator
   logic [30:0] s_mag;
   assign s_mag = mul_acc[30] ? 31'(-mul_acc[30:0]) : mul_acc[30:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      mul_cmd.start = mul_start;
      mul_cmd.clr   = 1'b0;
      mul_cmd.neg   = 1'b0;
      mul_cmd.nbits = 6'd16;
      case (op_sel)
         OP_PX: begin
            mul_a = 32'(psz_pkg::abs16(px_ff));
            mul_b = 32'(sd_ff);
            mul_cmd.clr = 1'b1;  mul_cmd.neg = px_ff[15];  mul_cmd.nbits = 6'd15;
         end
         OP_PY: begin
            mul_a = 32'(psz_pkg::abs16(py_ff));
            mul_b = 32'(sd_ff);
            mul_cmd.clr = 1'b1;  mul_cmd.neg = py_ff[15];  mul_cmd.nbits = 6'd15;
         end
         OP_NXX: begin
            mul_a = 32'(psz_pkg::abs16(nx_ff));
            mul_b = mul_a;
            mul_cmd.clr = 1'b1;
         end
         OP_NYY: begin
            mul_a = 32'(psz_pkg::abs16(ny_ff));
            mul_b = mul_a;
         end
         OP_NZZ: begin
            mul_a = 32'(psz_pkg::abs16(nz_ff));
            mul_b = mul_a;
         end
         OP_NXL: begin
            mul_a = 32'(psz_pkg::abs16(nx_ff));
            mul_b = 32'(psz_pkg::abs14(lx_ff));
            mul_cmd.clr = 1'b1;  mul_cmd.neg = nx_ff[15] ^ lx_ff[13];  mul_cmd.nbits = 6'd14;
         end
         OP_NYL: begin
            mul_a = 32'(psz_pkg::abs16(ny_ff));
            mul_b = 32'(psz_pkg::abs14(ly_ff));
            mul_cmd.neg = ny_ff[15] ^ ly_ff[13];  mul_cmd.nbits = 6'd14;
         end
         OP_NZL: begin
            mul_a = 32'(psz_pkg::abs16(nz_ff));
            mul_b = 32'(psz_pkg::abs14(lz_ff));
            mul_cmd.neg = nz_ff[15] ^ lz_ff[13];  mul_cmd.nbits = 6'd14;
         end
         OP_SSQ: begin
            mul_a = 32'(s_mag);
            mul_b = 32'(s_mag);
            mul_cmd.clr = 1'b1;  mul_cmd.nbits = 6'd31;
         end
         default: ;
      endcase
   end

   // projection divide setup straight from the finished product
   logic [63:0] n_mag;
   logic [63:0] sq_x9;
   assign n_mag = mul_acc[63] ? 64'(-mul_acc) : 64'(mul_acc);
   // 9 * s^2, s^2 stays below 2^60
   assign sq_x9 = {mul_acc[60:0], 3'b000} + 64'(mul_acc[59:0]);

   // screen cell from quotient and remainder of |N| / (pz * 256)
   logic          x_ok, y_ok;
   logic [XW-1:0] x_cell;
   logic [YW-1:0] y_cell;
   logic          rem_zero;
   logic [30:0]   x_sum, x_dif, y_sum, y_dif;

   assign rem_zero = div_rem == '0;
   assign x_sum = 31'(XHALF) + div_quo;
   assign x_dif = 31'(XHALF) - div_quo;
   assign y_sum = 31'(YHALF) + div_quo;
   assign y_dif = 31'(YHALF) - div_quo;

   always_comb begin
      if (nneg_ff) begin
         // negative coordinate: keep down to exactly minus half
         x_ok   = div_quo < 31'(XHALF) || (div_quo == 31'(XHALF) && rem_zero);
         y_ok   = div_quo < 31'(YHALF) || (div_quo == 31'(YHALF) && rem_zero);
         x_cell = x_dif[XW-1:0];
         y_cell = y_dif[YW-1:0];
      end else begin
         x_ok   = div_quo < 31'(XREST);
         y_ok   = div_quo < 31'(YREST);
         x_cell = x_sum[XW-1:0];
         y_cell = y_sum[YW-1:0];
      end
   end

   // shade level from q = floor(9 s^2 / (m 2^22)), compared to squares 1, 4, 9, 16, 25
   logic [8:0] q9;
   logic [3:0] shade_calc;
   logic [2:0] n_ge;

   assign q9 = div_quo[8:0];

   function automatic logic at_most(input logic [8:0] q, input logic [8:0] j2,
                                    input logic rz);
      at_most = q < j2 || (q == j2 && rz);
   endfunction

   always_comb begin
      n_ge = 3'(q9 >= 9'd1) + 3'(q9 >= 9'd4) + 3'(q9 >= 9'd9)
           + 3'(q9 >= 9'd16) + 3'(q9 >= 9'd25);
      if (!s_ff[30]) begin
         shade_calc = psz_pkg::SHADE_MID + 4'(n_ge);
      end else if (at_most(q9, 9'd1, rem_zero)) begin
         shade_calc = 4'd5;
      end else if (at_most(q9, 9'd4, rem_zero)) begin
         shade_calc = 4'd4;
      end else if (at_most(q9, 9'd9, rem_zero)) begin
         shade_calc = 4'd3;
      end else if (at_most(q9, 9'd16, rem_zero)) begin
         shade_calc = 4'd2;
      end else if (at_most(q9, 9'd25, rem_zero)) begin
         shade_calc = 4'd1;
      end else begin
         shade_calc = 4'd0;
      end
   end

   // pixel address: plot uses the projected cell, read the requested index
   assign pix_addr = (cmd_ff == psz_pkg::CMD_PLOT)
                   ? AW'(row_ff) * AW'(SCREEN_W) + AW'(col_ff)
                   : AW'(pidx_ff);

   logic pidx_in_range;
   assign pidx_in_range = 32'(req_tdata[106:96]) < 32'(NPIX);

   assign req_tready = (state_ff == ST_IDLE) && !clr_busy;

   logic win;
   assign win = !rd_data.valid || (pz_ff < rd_data.depth);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      term_in       = term_ff;
      cmd_in        = cmd_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      pz_in         = pz_ff;
      nx_in         = nx_ff;
      ny_in         = ny_ff;
      nz_in         = nz_ff;
      pidx_in       = pidx_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      nneg_in       = nneg_ff;
      m_in          = m_ff;
      s_in          = s_ff;
      shade_in      = shade_ff;
      res_plot_in   = res_plot_ff;
      res_hit_in    = res_hit_ff;
      res_char_in   = res_char_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      op_sel        = OP_PX;
      mul_start     = 1'b0;
      div_cmd       = '0;
      div_rem_init  = '0;
      div_num       = {n_mag[30:0], 33'b0};
      div_den       = 55'({pz_ff[14:0], 8'b0});
      clr_start     = 1'b0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_data       = '{valid: 1'b1, depth: pz_ff, shade: shade_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_in      = req_tuser;
               px_in       = req_tdata[15:0];
               py_in       = req_tdata[31:16];
               pz_in       = req_tdata[47:32];
               nx_in       = req_tdata[63:48];
               ny_in       = req_tdata[79:64];
               nz_in       = req_tdata[95:80];
               pidx_in     = req_tdata[106:96];
               res_plot_in = 1'b0;
               res_hit_in  = 1'b0;
               res_char_in = '0;
               case (req_tuser)
                  psz_pkg::CMD_CLEAR: begin
                     clr_start = 1'b1;
                     state_in  = ST_DONE;
                  end
                  psz_pkg::CMD_PLOT: state_in = ST_PCHK;
                  psz_pkg::CMD_READ: begin
                     if (pidx_in_range) begin
                        state_in = ST_RD;
                     end else begin
                        res_char_in = psz_pkg::CHAR_SPACE;
                        state_in    = ST_DONE;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_PCHK: begin
            // points at or behind the eye are dropped
            if (pz_ff[15] || pz_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               op_sel    = OP_PX;
               mul_start = 1'b1;
               state_in  = ST_XMUL;
            end
         end
         ST_XMUL, ST_YMUL: begin
            if (mul_done) begin
               nneg_in       = mul_acc[63];
               div_cmd.start = 1'b1;
               div_cmd.qbits = 6'd31;
               state_in      = (state_ff == ST_XMUL) ? ST_XDIV : ST_YDIV;
            end
         end
         ST_XDIV: begin
            if (div_done) begin
               if (x_ok) begin
                  col_in    = x_cell;
                  op_sel    = OP_PY;
                  mul_start = 1'b1;
                  state_in  = ST_YMUL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_YDIV: begin
            if (div_done) begin
               if (y_ok) begin
                  row_in    = y_cell;
                  term_in   = OP_NXX;
                  op_sel    = OP_NXX;
                  mul_start = 1'b1;
                  state_in  = ST_SHMUL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SHMUL: begin
            if (mul_done) begin
               if (term_ff == OP_NZZ) begin
                  m_in = mul_acc[31:0];
               end
               if (term_ff == OP_NZL) begin
                  s_in = mul_acc[30:0];
               end
               if (term_ff == OP_SSQ) begin
                  // zero normal shades as level zero
                  if (m_ff == '0) begin
                     shade_in = '0;
                     state_in = ST_RD;
                  end else begin
                     div_cmd.start = 1'b1;
                     div_cmd.qbits = 6'd9;
                     div_rem_init  = 56'(sq_x9 >> 9);
                     div_num       = {sq_x9[8:0], 55'b0};
                     div_den       = 55'({m_ff, 22'b0});
                     state_in      = ST_SHDIV;
                  end
               end else begin
                  term_in   = term_ff + 4'd1;
                  op_sel    = term_ff + 4'd1;
                  mul_start = 1'b1;
               end
            end
         end
         ST_SHDIV: begin
            if (div_done) begin
               shade_in = shade_calc;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            rd_en    = 1'b1;
            state_in = ST_RDW;
         end
         ST_RDW: begin
            if (cmd_ff == psz_pkg::CMD_PLOT) begin
               // equal depth keeps the stored point
               wr_en       = win;
               res_plot_in = win;
            end else begin
               res_hit_in  = rd_data.valid;
               res_char_in = rd_data.valid ? psz_pkg::shade_char(rd_data.shade)
                                           : psz_pkg::CHAR_SPACE;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {7'b0, res_char_ff, res_hit_ff, res_plot_ff};
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      term_ff      <= term_in;
      cmd_ff       <= cmd_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      pz_ff        <= pz_in;
      nx_ff        <= nx_in;
      ny_ff        <= ny_in;
      nz_ff        <= nz_in;
      pidx_ff      <= pidx_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      nneg_ff      <= nneg_in;
      m_ff         <= m_in;
      s_ff         <= s_in;
      shade_ff     <= shade_in;
      res_plot_ff  <= res_plot_in;
      res_hit_ff   <= res_hit_in;
      res_char_ff  <= res_char_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // a plot never writes the store while the clearing sweep owns it
   assert property (@(posedge clock) disable iff (reset) wr_en |-> !clr_busy)
      else $error("pixel write during clearing sweep");

   // a new result only appears out of the done state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside done state");

   // the read data is consumed in the cycle after the read is issued
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RDW |-> $past(state_ff) == ST_RD)
      else $error("store data used without a read");

   // divider only starts from a state that waits on a finished product
   assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |-> mul_done)
      else $error("divide started without a product");

endmodule

FILE: sim/point_splat_zbuffer_shader_checker.sv
// checker for the point splat z-buffer shader: tracks register writes, predicts results
// depends on psz_pkg; watches the req_, rsp_ and csr_ ports of the block
`timescale 1ns / 1ps

module point_splat_zbuffer_shader_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [111:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [15:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [14:0]  csr_wdata,
   output int           errors,
   output int           pending
);

   localparam int W   = 40;
   localparam int H   = 40;
   localparam int NPX = W * H;

   typedef struct packed {
      logic       plotted;
      logic       pixel_hit;
      logic [6:0] char_code;
   } pixel_result_type;

   pixel_result_type result_queue[$];
   string            glyphs = ".,-~:;=!*#$@";

   logic [14:0] scr_dist;
   logic [13:0] lgt_x, lgt_y, lgt_z;
   logic        zb_valid[NPX];
   logic [15:0] zb_depth[NPX];
   logic [3:0]  zb_shade[NPX];

   assign pending = result_queue.size();

   // exact compare of 3*s against (k-6)*2048*sqrt(m)
   function automatic bit level_ok(longint s, longint m, int k);
      longint a, b, aa, bb;
      a  = 3 * s;
      b  = longint'(k - 6) * 2048;
      aa = a < 0 ? -a : a;
      bb = b < 0 ? -b : b;
      if (b >= 0) return a >= 0 && aa * aa >= bb * bb * m;
      if (a >= 0) return 1;
      return aa * aa <= bb * bb * m;
   endfunction

   function automatic logic [3:0] lambert_level(longint nx, longint ny, longint nz);
      longint m, s;
      m = nx * nx + ny * ny + nz * nz;
      s = nx * longint'($signed(lgt_x)) + ny * longint'($signed(lgt_y))
          + nz * longint'($signed(lgt_z));
      if (m == 0) return 0;
      for (int k = 11; k >= 1; k--)
         if (level_ok(s, m, k)) return 4'(k);
      return 0;
   endfunction

   function automatic bit screen_cell(longint n, longint d, int size, output int slot);
      longint half;
      half = size / 2;
      slot = 0;
      if (n < -half * d || n >= (size - half) * d) return 0;
      slot = int'(n / d + half);
      return slot >= 0 && slot < size;
   endfunction

   function automatic pixel_result_type splat_and_read(logic [1:0] cmd, logic [111:0] d);
      pixel_result_type r;
      longint px, py, pz, dd;
      int col, row, idx;
      r = '0;
      case (cmd)
         psz_pkg::CMD_CLEAR: for (int i = 0; i < NPX; i++) zb_valid[i] = 0;
         psz_pkg::CMD_PLOT: begin
            px = longint'($signed(d[15:0]));
            py = longint'($signed(d[31:16]));
            pz = longint'($signed(d[47:32]));
            dd = pz * 256;
            if (pz > 0 && screen_cell(px * longint'(scr_dist), dd, W, col)
                && screen_cell(py * longint'(scr_dist), dd, H, row)) begin
               idx = row * W + col;
               if (!zb_valid[idx] || pz < longint'(zb_depth[idx])) begin
                  zb_valid[idx] = 1;
                  zb_depth[idx] = d[47:32];
                  zb_shade[idx] = lambert_level(longint'($signed(d[63:48])),
                                                longint'($signed(d[79:64])),
                                                longint'($signed(d[95:80])));
                  r.plotted = 1;
               end
            end
         end
         psz_pkg::CMD_READ: begin
            idx = int'(d[106:96]);
            if (idx < NPX && zb_valid[idx]) begin
               r.pixel_hit = 1;
               r.char_code = 7'(glyphs[zb_shade[idx] > 11 ? 11 : zb_shade[idx]]);
            end else begin
               r.char_code = psz_pkg::CHAR_SPACE;
            end
         end
         default: ;  // unused command, all fields stay zero
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      pixel_result_type want;
      pixel_result_type got;
      if (reset) begin
         errors   = 0;
         scr_dist = psz_pkg::SCREEN_DIST_RST;
         lgt_x    = psz_pkg::LIGHT_X_RST;
         lgt_y    = psz_pkg::LIGHT_Y_RST;
         lgt_z    = psz_pkg::LIGHT_Z_RST;
         for (int i = 0; i < NPX; i++) zb_valid[i] = 0;
         result_queue.delete();
      end else begin
         // compare first: a result always belongs to an earlier transfer
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[0], rsp_tdata[1], rsp_tdata[8:2]};
            if (result_queue.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
               errors++;
            end else begin
               want = result_queue.pop_front();
               if (got.plotted !== want.plotted) begin
                  $display("%0t: plotted expected %0d actual %0d",
                           $time, want.plotted, got.plotted);
                  errors++;
               end
               if (got.pixel_hit !== want.pixel_hit) begin
                  $display("%0t: pixel_hit expected %0d actual %0d",
                           $time, want.pixel_hit, got.pixel_hit);
                  errors++;
               end
               if (got.char_code !== want.char_code) begin
                  $display("%0t: char_code expected %0d actual %0d",
                           $time, want.char_code, got.char_code);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready)
            result_queue.push_back(splat_and_read(req_tuser, req_tdata));
         if (csr_we)
            case (csr_addr)
               psz_pkg::CSR_SCREEN_DIST: scr_dist = csr_wdata;
               psz_pkg::CSR_LIGHT_X:     lgt_x = csr_wdata[13:0];
               psz_pkg::CSR_LIGHT_Y:     lgt_y = csr_wdata[13:0];
               psz_pkg::CSR_LIGHT_Z:     lgt_z = csr_wdata[13:0];
               default: ;
            endcase
      end
   end

endmodule

FILE: sim/point_splat_zbuffer_shader_tb.sv
// testbench top for the point splat z-buffer shader: clock, reset, stimulus, verdict
// depends on psz_pkg, point_splat_zbuffer_shader and point_splat_zbuffer_shader_checker
`timescale 1ns / 1ps

module point_splat_zbuffer_shader_tb;

   localparam int STALL_LIMIT = 6000;   // cycles with no transfer at all
   localparam int SETTLE      = 300;    // wait once the results have drained
   localparam int PER_PHASE   = 210;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [111:0] req_tdata;   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, pixel_index
   logic [1:0]   req_tuser;   // cmd
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [15:0]  rsp_tdata;   // plotted, pixel_hit, char_code
   logic         csr_we;
   logic [1:0]   csr_addr;
   logic [14:0]  csr_wdata;
   int           errors;
   int           pending;

   bit           no_idle;       // stretch with no gaps on either side
   bit           hold_rsp;      // ask the receiver for one long hold-off
   int           quiet_cycles;
   longint       cur_dist;

   point_splat_zbuffer_shader i_dut (.*);

   point_splat_zbuffer_shader_checker i_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // watchdog: no transfer of any kind for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("point_splat_zbuffer_shader verification failed");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready = 0;
            repeat (600) @(negedge clock);
            hold_rsp = 0;
         end
         rsp_tready = no_idle || ($urandom_range(99) >= 9);
      end
   end

   function automatic logic [111:0] pack_item(logic [15:0] px, py, pz, nx, ny, nz,
                                              logic [10:0] idx);
      return {5'b0, idx, nz, ny, nx, pz, py, px};
   endfunction

   task automatic send(input logic [1:0] cmd, input logic [111:0] data);
      while (!no_idle && $urandom_range(99) < 9) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser  = cmd;
      req_tdata  = data;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] addr, input logic [14:0] value);
      csr_we    = 1;
      csr_addr  = addr;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 0;
   endtask

   // drain everything, then reprogram the registers while the block is idle
   task automatic new_setting(input logic [14:0] sdist, input logic [13:0] lx, ly, lz);
      req_tvalid = 0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_write(psz_pkg::CSR_SCREEN_DIST, sdist);
      csr_write(psz_pkg::CSR_LIGHT_X, {1'b0, lx});
      csr_write(psz_pkg::CSR_LIGHT_Y, {1'b0, ly});
      csr_write(psz_pkg::CSR_LIGHT_Z, {1'b0, lz});
      cur_dist = longint'(sdist);
   endtask

   // plot aimed at the screen with a random normal
   task automatic aimed_plot();
      longint pz, lim, px, py;
      pz  = $urandom_range(7) == 0 ? longint'($urandom_range(32767, 1))
                                   : longint'($urandom_range(8192, 64));
      lim = cur_dist == 0 ? 32767 : pz * 20 * 256 / cur_dist;
      if (lim > 32767) lim = 32767;
      px  = longint'($urandom_range(32'(2 * lim))) - lim;
      py  = longint'($urandom_range(32'(2 * lim))) - lim;
      send(psz_pkg::CMD_PLOT, pack_item(16'(px), 16'(py), 16'(pz), 16'($urandom),
                               16'($urandom_range(8192)) - 16'd4096,
                               16'($urandom_range(8192)) - 16'd4096, 11'($urandom)));
   endtask

   task automatic random_phase();
      int pick;
      for (int i = 0; i < PER_PHASE; i++) begin
         pick = $urandom_range(99);
         if (pick < 62)      aimed_plot();
         else if (pick < 84) send(psz_pkg::CMD_READ, pack_item(16'($urandom),
                                  16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom),
                                  11'($urandom_range(1599))));
         else if (pick < 86) send(psz_pkg::CMD_CLEAR, 112'(0));
         // noise: every field and command at random, padding kept zero
         else                send(2'($urandom), pack_item(16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 11'($urandom)));
      end
   endtask

   initial begin
      reset      = 1;
      req_tvalid = 0;
      req_tuser  = psz_pkg::CMD_CLEAR;
      req_tdata  = '0;
      csr_we     = 0;
      csr_addr   = psz_pkg::CSR_SCREEN_DIST;
      csr_wdata  = '0;
      no_idle    = 0;
      hold_rsp   = 0;
      cur_dist   = longint'(psz_pkg::SCREEN_DIST_RST);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: empty reads, centre plot, depth tie, nearer point, drops, edges
      send(psz_pkg::CMD_READ, pack_item(0, 0, 0, 0, 0, 0, 11'd820));
      send(psz_pkg::CMD_PLOT, pack_item(0, 0, 16'd256, 0, 16'hF000, 0, 0));
      send(psz_pkg::CMD_READ, pack_item(0, 0, 0, 0, 0, 0, 11'd820));
      send(psz_pkg::CMD_PLOT, pack_item(0, 0, 16'd256, 16'd4096, 0, 0, 0)); // tie, kept old
      send(psz_pkg::CMD_PLOT, pack_item(0, 0, 16'd255, 0, 16'd4096, 0, 0)); // nearer wins
      send(psz_pkg::CMD_READ, pack_item(0, 0, 0, 0, 0, 0, 11'd820));
      send(psz_pkg::CMD_PLOT, pack_item(0, 0, 16'd0, 0, 0, 0, 0));          // z zero
      send(psz_pkg::CMD_PLOT, pack_item(0, 0, 16'h8000, 0, 0, 0, 0));       // z negative
      send(psz_pkg::CMD_PLOT, pack_item(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                               16'h7FFF, 11'h7FF));
      send(psz_pkg::CMD_PLOT, pack_item(16'h8000, 16'h8000, 16'd1, 0, 0, 0, 0)); // off screen
      send(psz_pkg::CMD_PLOT, pack_item(16'hEC00, 16'hEC00, 16'd3840, 0, 0, 0, 0)); // top left
      send(psz_pkg::CMD_PLOT, pack_item(16'd5120, 0, 16'd3840, 0, 0, 0, 0)); // right, dropped
      send(psz_pkg::CMD_PLOT, pack_item(16'd5119, 16'd5119, 16'd3840, 0, 0, 0, 0)); // bottom
      send(psz_pkg::CMD_PLOT, pack_item(16'd100, 16'd100, 16'd1000, 0, 0, 0, 0)); // zero normal
      send(psz_pkg::CMD_READ, pack_item(0, 0, 0, 0, 0, 0, 11'd0));
      send(psz_pkg::CMD_READ, pack_item(0, 0, 0, 0, 0, 0, 11'd1599));
      send(psz_pkg::CMD_READ, pack_item(0, 0, 0, 0, 0, 0, 11'd1600));       // out of range
      send(psz_pkg::CMD_READ, pack_item(0, 0, 0, 0, 0, 0, 11'h7FF));
      send(2'd3, pack_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           16'hFFFF, 11'h7FF));                           // unused command
      send(psz_pkg::CMD_CLEAR, 112'(0));
      send(psz_pkg::CMD_READ, pack_item(0, 0, 0, 0, 0, 0, 11'd820));
      random_phase();

      // nearest plane, light along +x
      new_setting(15'd256, 14'd4096, 14'd0, 14'd0);
      random_phase();

      // farthest plane, light toward the viewer; receiver holds off while items queue
      new_setting(15'h7FFF, 14'd0, 14'd0, -14'sd4096);
      hold_rsp = 1;
      random_phase();

      // zero distance and a light far from unit length, no gaps at all
      new_setting(15'd0, 14'h1FFF, 14'h2000, 14'd2896);
      no_idle = 1;
      random_phase();
      no_idle = 0;

      new_setting(15'($urandom_range(8000, 256)), 14'($urandom_range(8192)) - 14'd4096,
                  14'($urandom_range(8192)) - 14'd4096, 14'($urandom_range(8192)) - 14'd4096);
      random_phase();

      req_tvalid = 0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (errors == 0)
         $display("point_splat_zbuffer_shader verification clean");
      else
         $display("point_splat_zbuffer_shader verification failed");
      $finish;
   end

endmodule
